// ===== design/assert_macros.svh =====
// Assertion macros shared by the CRC-16 frame checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define CRCFC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CRCFC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/crcfc_pkg.sv =====
// Shared types, constants and the CRC step function of the CRC-16 frame checker.
`timescale 1ns / 1ps

package crcfc_pkg;

  localparam int CRC_SPAN     = 14;
  localparam int FRAME_LEN    = 16;
  localparam int BUFFER_BYTES = 32;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int COUNT_OUT_W  = 6;
  localparam int CFG_IDX_W    = 8;

  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_INIT    = 16'h0000;
  localparam logic [7:0]  HDR0_RESET  = 8'hFD;
  localparam logic [7:0]  HDR1_RESET  = 8'hEE;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = CFG_IDX_W'(1);

  typedef enum logic [0:0] {
    OP_DATA = 1'b0,
    OP_IDLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_TOO_SHORT    = 2'd1,
    ST_BAD_HEADER   = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crcfc_front.sv =====
// Front end: takes input beats, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crcfc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  pop,
  output crcfc_pkg::queue_head_t head
);

  crcfc_pkg::item_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  crcfc_pkg::item_t in_item;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;

  always_comb begin
    in_item.op   = s_tuser ? crcfc_pkg::OP_IDLE : crcfc_pkg::OP_DATA;
    in_item.data = s_tdata;
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `CRCFC_ASSERT_ALWAYS(a_count_bound, clk, rst || count <= 2'd2, "queue count out of range")
  `CRCFC_ASSERT(a_pop_nonempty, clk, rst, pop |-> head.valid, "pop from an empty queue")

endmodule

// ===== design/crcfc_back.sv =====
// Back end: frame state, CRC update, header registers and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crcfc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  crcfc_pkg::queue_head_t            head,
  output logic                              pop,
  input  logic                              cfg_valid,
  input  logic [crcfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata
);

  logic [7:0]                  header_first;
  logic [7:0]                  header_second;
  logic [15:0]                 crc_reg;
  logic [crcfc_pkg::CNT_W-1:0] byte_counter;
  logic [7:0]                  first_byte;
  logic [7:0]                  second_byte;
  logic [7:0]                  crc_low_byte;
  logic [7:0]                  crc_high_byte;

  logic                        out_valid;
  crcfc_pkg::status_t          out_status;
  logic [crcfc_pkg::COUNT_OUT_W-1:0] out_count;
  logic [15:0]                 out_calc;
  logic [15:0]                 out_recv;

  logic                        is_idle;
  logic                        take_data;
  logic                        take_idle;
  logic                        room;
  logic [15:0]                 rx_crc_word;
  crcfc_pkg::status_t          status_next;

  assign is_idle     = (head.item.op == crcfc_pkg::OP_IDLE);
  assign pop         = head.valid && (!is_idle || !out_valid || m_tready);
  assign take_idle   = pop && is_idle;
  assign take_data   = pop && !is_idle;
  assign room        = byte_counter < crcfc_pkg::CNT_W'(crcfc_pkg::BUFFER_BYTES);
  assign rx_crc_word = {crc_high_byte, crc_low_byte};

  always_comb begin
    if (byte_counter < crcfc_pkg::CNT_W'(crcfc_pkg::FRAME_LEN)) begin
      status_next = crcfc_pkg::ST_TOO_SHORT;
    end else if (first_byte != header_first || second_byte != header_second) begin
      status_next = crcfc_pkg::ST_BAD_HEADER;
    end else if (crc_reg != rx_crc_word) begin
      status_next = crcfc_pkg::ST_CRC_MISMATCH;
    end else begin
      status_next = crcfc_pkg::ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= crcfc_pkg::HDR0_RESET;
      header_second <= crcfc_pkg::HDR1_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == crcfc_pkg::REG_HEADER_FIRST) begin
        header_first <= cfg_data;
      end else if (cfg_index == crcfc_pkg::REG_HEADER_SECOND) begin
        header_second <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || take_idle) begin
      crc_reg       <= crcfc_pkg::CRC_INIT;
      byte_counter  <= '0;
      first_byte    <= 8'h00;
      second_byte   <= 8'h00;
      crc_low_byte  <= 8'h00;
      crc_high_byte <= 8'h00;
    end else if (take_data && room) begin
      if (byte_counter == crcfc_pkg::CNT_W'(0)) begin
        first_byte <= head.item.data;
      end
      if (byte_counter == crcfc_pkg::CNT_W'(1)) begin
        second_byte <= head.item.data;
      end
      if (byte_counter < crcfc_pkg::CNT_W'(crcfc_pkg::CRC_SPAN)) begin
        crc_reg <= crcfc_pkg::crc_update(crc_reg, head.item.data);
      end
      if (byte_counter == crcfc_pkg::CNT_W'(crcfc_pkg::CRC_SPAN)) begin
        crc_low_byte <= head.item.data;
      end
      if (byte_counter == crcfc_pkg::CNT_W'(crcfc_pkg::CRC_SPAN + 1)) begin
        crc_high_byte <= head.item.data;
      end
      byte_counter <= byte_counter + crcfc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_idle) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_idle) begin
      out_status <= status_next;
      out_count  <= crcfc_pkg::COUNT_OUT_W'(byte_counter);
      out_calc   <= crc_reg;
      out_recv   <= rx_crc_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_recv, out_calc, out_count, out_status};

  `CRCFC_ASSERT_ALWAYS(a_count_sat, clk, rst || byte_counter <= crcfc_pkg::CNT_W'(crcfc_pkg::BUFFER_BYTES), "byte counter past buffer size")
  `CRCFC_ASSERT(a_clear_after_idle, clk, rst, take_idle |=> (byte_counter == '0 && crc_reg == crcfc_pkg::CRC_INIT), "frame state not cleared after idle")

endmodule

// ===== design/crc16_frame_receive_checker.sv =====
// Top level of the CRC-16 frame receive checker.
`timescale 1ns / 1ps

// Checks received frames: each input beat is either a data byte (s_tuser low) or a
// line-idle event (s_tuser high) that closes the frame and produces one result beat
// with the status, the saturated byte count, the CRC computed over the first bytes
// and the CRC received after them. Input beats are taken at one per clock. The frame
// logic consumes a data beat every cycle; an idle beat waits at the head of a
// two-entry queue while an earlier result is still held on the output by a low
// m_tready, and once the queue fills behind it s_tready drops and every further beat,
// data included, waits until that result is taken. With nothing waiting ahead of it,
// an idle beat leaves the queue at the rising edge after it is accepted and m_tvalid
// rises at that same edge. Header values are written through the cfg port, which is
// always ready; write them only while no frame beat is in flight, and they take
// effect for the next frame check.
module crc16_frame_receive_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
  input  logic                            s_tuser,   // [0] req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,   // [1:0] frame_status, [7:2] byte_count,
                                                     // [23:8] calc_crc, [39:24] received CRC
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crcfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  crcfc_pkg::queue_head_t head;
  logic                   pop;

  assign cfg_ready = 1'b1;

  crcfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .pop      (pop),
    .head     (head)
  );

  crcfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
